[rtl/fbpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier: shared package
// Types, register indexes, event codes and reset values used across the block.
// ----------------------------------------------------------------------------
package fbpc_pkg;

   localparam int unsigned CntW  = 16;
   localparam int unsigned SubW  = 8;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 16;

   typedef logic [CntW-1:0] cnt_type;
   typedef logic [SubW-1:0] sub_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_HOLD    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BTN_POWER = 2'd0,
      BTN_SET   = 2'd1,
      BTN_DOWN  = 2'd2,
      BTN_UP    = 2'd3
   } button_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_HOLD_TICKS     = 3'd0,
      REG_HOLD_CAP       = 3'd1,
      REG_SET_PRESCALE   = 3'd2,
      REG_SET_LONG_COUNT = 3'd3,
      REG_SET_SHORT_MIN  = 3'd4,
      REG_SET_SHORT_MAX  = 3'd5,
      REG_SET_CAP        = 3'd6
   } reg_index_type;

   localparam cnt_type RstHoldTicks    = 16'd100;
   localparam cnt_type RstHoldCap      = 16'd2000;
   localparam sub_type RstSetPrescale  = 8'd30;
   localparam cnt_type RstSetLongCount = 16'd8000;
   localparam cnt_type RstSetShortMin  = 16'd30;
   localparam cnt_type RstSetShortMax  = 16'd7900;
   localparam cnt_type RstSetCap       = 16'd65000;

   typedef struct packed {
      cnt_type hold_ticks;
      cnt_type hold_cap;
      sub_type set_prescale;
      cnt_type set_long_count;
      cnt_type set_short_min;
      cnt_type set_short_max;
      cnt_type set_cap;
   } cfg_type;

   typedef struct packed {
      logic power_level;
      logic set_level;
      logic down_level;
      logic up_level;
   } levels_type;

endpackage

[rtl/fbpc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier: request channel
// Carries one scan tick of the four active-low button levels.
// ----------------------------------------------------------------------------
interface fbpc_req_if;
   logic valid;
   logic ready;
   logic power_level;
   logic set_level;
   logic down_level;
   logic up_level;

   modport source (
      output valid, power_level, set_level, down_level, up_level,
      input  ready
   );
   modport sink (
      input  valid, power_level, set_level, down_level, up_level,
      output ready
   );
endinterface

[rtl/fbpc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier: response channel
// Carries the event reported for one scan tick.
// ----------------------------------------------------------------------------
interface fbpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [1:0] button_id;

   modport source (
      output valid, event_kind, button_id,
      input  ready
   );
   modport sink (
      input  valid, event_kind, button_id,
      output ready
   );
endinterface

[rtl/four_button_press_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier
// Throughput: one scan tick per clock while the response is not stalled;
// the counter update is a single pass of compare and increment logic between
// the input and result registers. Reset (synchronous, active high) clears all
// counters and both pipeline valids and loads the default settings into the
// configuration registers.
// ----------------------------------------------------------------------------
module four_button_press_classifier
   import fbpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   fbpc_req_if.sink            req,
   fbpc_rsp_if.source          rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   levels_type in_levels_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff;
   button_type rsp_id_ff;

   cnt_type power_held_ff, power_held_in;
   sub_type set_sub_ff, set_sub_in;
   cnt_type set_held_ff, set_held_in;
   cnt_type down_held_ff, down_held_in;
   cnt_type up_held_ff, up_held_in;

   cnt_type  power_nx, set_held_nx, down_nx, up_nx;
   sub_type  set_sub_nx;
   kind_type power_kind, set_kind, down_kind, up_kind;
   kind_type kind_in;
   button_type id_in;

   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HOLD_TICKS:     cfg_in.hold_ticks     = csr_wdata;
            REG_HOLD_CAP:       cfg_in.hold_cap       = csr_wdata;
            REG_SET_PRESCALE:   cfg_in.set_prescale   = csr_wdata[SubW-1:0];
            REG_SET_LONG_COUNT: cfg_in.set_long_count = csr_wdata;
            REG_SET_SHORT_MIN:  cfg_in.set_short_min  = csr_wdata;
            REG_SET_SHORT_MAX:  cfg_in.set_short_max  = csr_wdata;
            REG_SET_CAP:        cfg_in.set_cap        = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   fbpc_plain_btn u_power (
      .held       (power_held_ff),
      .pressed    (!in_levels_ff.power_level),
      .hold_ticks (cfg_ff.hold_ticks),
      .hold_cap   (cfg_ff.hold_cap),
      .held_next  (power_nx),
      .kind       (power_kind)
   );

   fbpc_set_btn u_set (
      .sub        (set_sub_ff),
      .held       (set_held_ff),
      .pressed    (!in_levels_ff.set_level),
      .cfg        (cfg_ff),
      .sub_next   (set_sub_nx),
      .held_next  (set_held_nx),
      .kind       (set_kind)
   );

   fbpc_plain_btn u_down (
      .held       (down_held_ff),
      .pressed    (!in_levels_ff.down_level),
      .hold_ticks (cfg_ff.hold_ticks),
      .hold_cap   (cfg_ff.hold_cap),
      .held_next  (down_nx),
      .kind       (down_kind)
   );

   fbpc_plain_btn u_up (
      .held       (up_held_ff),
      .pressed    (!in_levels_ff.up_level),
      .hold_ticks (cfg_ff.hold_ticks),
      .hold_cap   (cfg_ff.hold_cap),
      .held_next  (up_nx),
      .kind       (up_kind)
   );

   // Priority: once a button reports, the buttons after it keep their state.
   always_comb begin
      power_held_in = power_held_ff;
      set_sub_in    = set_sub_ff;
      set_held_in   = set_held_ff;
      down_held_in  = down_held_ff;
      up_held_in    = up_held_ff;
      kind_in       = KIND_NONE;
      id_in         = BTN_POWER;
      if (advance) begin
         power_held_in = power_nx;
         if (power_kind != KIND_NONE) begin
            kind_in = power_kind;
            id_in   = BTN_POWER;
         end else begin
            set_sub_in  = set_sub_nx;
            set_held_in = set_held_nx;
            if (set_kind != KIND_NONE) begin
               kind_in = set_kind;
               id_in   = BTN_SET;
            end else begin
               down_held_in = down_nx;
               if (down_kind != KIND_NONE) begin
                  kind_in = down_kind;
                  id_in   = BTN_DOWN;
               end else begin
                  up_held_in = up_nx;
                  if (up_kind != KIND_NONE) begin
                     kind_in = up_kind;
                     id_in   = BTN_UP;
                  end
               end
            end
         end
      end
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks     <= RstHoldTicks;
         cfg_ff.hold_cap       <= RstHoldCap;
         cfg_ff.set_prescale   <= RstSetPrescale;
         cfg_ff.set_long_count <= RstSetLongCount;
         cfg_ff.set_short_min  <= RstSetShortMin;
         cfg_ff.set_short_max  <= RstSetShortMax;
         cfg_ff.set_cap        <= RstSetCap;
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         power_held_ff         <= '0;
         set_sub_ff            <= '0;
         set_held_ff           <= '0;
         down_held_ff          <= '0;
         up_held_ff            <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         power_held_ff <= power_held_in;
         set_sub_ff    <= set_sub_in;
         set_held_ff   <= set_held_in;
         down_held_ff  <= down_held_in;
         up_held_ff    <= up_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_levels_ff.power_level <= req.power_level;
         in_levels_ff.set_level   <= req.set_level;
         in_levels_ff.down_level  <= req.down_level;
         in_levels_ff.up_level    <= req.up_level;
      end
      if (advance) begin
         rsp_kind_ff <= kind_in;
         rsp_id_ff   <= id_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = rsp_kind_ff;
   assign rsp.button_id  = rsp_id_ff;

endmodule

[rtl/fbpc_plain_btn.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier: plain button update
// Next held count and event for a hold/release button (power, down, up).
// ----------------------------------------------------------------------------
module fbpc_plain_btn
   import fbpc_pkg::*;
(
   input  cnt_type  held,
   input  logic     pressed,
   input  cnt_type  hold_ticks,
   input  cnt_type  hold_cap,
   output cnt_type  held_next,
   output kind_type kind
);

   cnt_type held_inc;

   assign held_inc = held + cnt_type'(1);

   always_comb begin
      held_next = held;
      kind      = KIND_NONE;
      if (pressed) begin
         if (held < hold_cap) begin
            held_next = held_inc;
            if (held_inc == hold_ticks) begin
               kind = KIND_HOLD;
            end
         end
      end else begin
         held_next = '0;
         if (held > hold_ticks) begin
            kind = KIND_RELEASE;
         end
      end
   end

endmodule

[rtl/fbpc_set_btn.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier: set button update
// Prescaled held count with long-hold and short-press detection.
// ----------------------------------------------------------------------------
module fbpc_set_btn
   import fbpc_pkg::*;
(
   input  sub_type  sub,
   input  cnt_type  held,
   input  logic     pressed,
   input  cfg_type  cfg,
   output sub_type  sub_next,
   output cnt_type  held_next,
   output kind_type kind
);

   cnt_type held_inc;

   assign held_inc = held + cnt_type'(1);

   always_comb begin
      sub_next  = sub;
      held_next = held;
      kind      = KIND_NONE;
      if (pressed) begin
         if (sub < cfg.set_prescale) begin
            sub_next = sub + sub_type'(1);
         end else begin
            sub_next = '0;
            if (held < cfg.set_cap) begin
               held_next = held_inc;
               if (held_inc == cfg.set_long_count) begin
                  kind = KIND_HOLD;
               end
            end
         end
      end else begin
         // The prescaler keeps its phase across a release.
         held_next = '0;
         if ((held > cfg.set_short_min) && (held < cfg.set_short_max)) begin
            kind = KIND_RELEASE;
         end
      end
   end

endmodule

[bench/four_button_press_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-button press classifier testbench
// Drives scan ticks of button levels through the request channel and checks
// every response against a cycle-free model of the counters and thresholds.
// Directed tests cover priority, hold, release, short and long set presses
// and the register extremes. Random phases then replay press sequences with
// random settings, random sender gaps and random response back-pressure.
// ----------------------------------------------------------------------------
module four_button_press_classifier_tb;
   import fbpc_pkg::*;

   localparam int ClockHalf    = 4;
   localparam int ResetCycles  = 12;
   localparam int SettleCycles = 6;
   localparam int CycleLimit   = 400000;
   localparam int PrintLimit   = 100;
   localparam int RandomPhases = 6;
   localparam int PhaseTicks   = 100;
   localparam int NoisePercent = 15;
   localparam logic [CsrIdxW-1:0] UnusedRegIndex = 3'd7;

   typedef struct packed {
      kind_type   kind;
      button_type btn;
   } press_event_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_BLOCK
   } stall_mode_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   fbpc_req_if req_ch ();
   fbpc_rsp_if rsp_ch ();

   four_button_press_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // Model state: settings and the five counters of the block.
   cfg_type cfg;
   cnt_type power_cnt;
   sub_type set_sub_cnt;
   cnt_type set_cnt;
   cnt_type down_cnt;
   cnt_type up_cnt;

   press_event_type expected_events[$];
   press_event_type oldest_event;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   stall_mode_type  stall_mode = STALL_NONE;
   int              stall_span = 0;

   function automatic kind_type track_plain(inout cnt_type held, input logic pressed);
      kind_type k;
      k = KIND_NONE;
      if (pressed) begin
         if (held < cfg.hold_cap) begin
            held = held + 1'b1;
            if (held == cfg.hold_ticks) k = KIND_HOLD;
         end
      end else begin
         if (held > cfg.hold_ticks) k = KIND_RELEASE;
         held = '0;
      end
      return k;
   endfunction

   function automatic kind_type track_set(input logic pressed);
      kind_type k;
      k = KIND_NONE;
      if (pressed) begin
         if (set_sub_cnt < cfg.set_prescale) begin
            set_sub_cnt = set_sub_cnt + 1'b1;
         end else begin
            set_sub_cnt = '0;
            if (set_cnt < cfg.set_cap) begin
               set_cnt = set_cnt + 1'b1;
               if (set_cnt == cfg.set_long_count) k = KIND_HOLD;
            end
         end
      end else begin
         if (set_cnt > cfg.set_short_min && set_cnt < cfg.set_short_max) k = KIND_RELEASE;
         // The prescaler keeps its phase across a release.
         set_cnt = '0;
      end
      return k;
   endfunction

   // Buttons are visited in priority order; once one reports, the rest keep
   // their counters for this tick.
   function automatic press_event_type classify_tick(levels_type lv);
      press_event_type ev;
      ev.btn  = BTN_POWER;
      ev.kind = track_plain(power_cnt, !lv.power_level);
      if (ev.kind == KIND_NONE) begin
         ev.btn  = BTN_SET;
         ev.kind = track_set(!lv.set_level);
      end
      if (ev.kind == KIND_NONE) begin
         ev.btn  = BTN_DOWN;
         ev.kind = track_plain(down_cnt, !lv.down_level);
      end
      if (ev.kind == KIND_NONE) begin
         ev.btn  = BTN_UP;
         ev.kind = track_plain(up_cnt, !lv.up_level);
      end
      if (ev.kind == KIND_NONE) ev.btn = BTN_POWER;
      return ev;
   endfunction

   function automatic levels_type make_levels(bit power_dn, bit set_dn, bit down_dn,
                                              bit up_dn);
      levels_type lv;
      lv.power_level = !power_dn;
      lv.set_level   = !set_dn;
      lv.down_level  = !down_dn;
      lv.up_level    = !up_dn;
      return lv;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < PrintLimit)
         $display("MISMATCH %s: got %0d, expected %0d, cycle %0d", what, got, want,
                  cycle_count);
      mismatch_count++;
   endtask

   // Predict on every request transaction, check every response transaction.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_events.push_back(classify_tick({req_ch.power_level, req_ch.set_level,
                                                     req_ch.down_level, req_ch.up_level}));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("response with nothing outstanding, kind",
                               rsp_ch.event_kind, KIND_NONE);
            end else begin
               oldest_event = expected_events.pop_front();
               if (rsp_ch.event_kind !== oldest_event.kind)
                  report_mismatch("event_kind", rsp_ch.event_kind, oldest_event.kind);
               if (rsp_ch.button_id !== oldest_event.btn)
                  report_mismatch("button_id", rsp_ch.button_id, oldest_event.btn);
            end
         end
      end
   end

   // Response back-pressure: stretches of always-ready, random, sparse and
   // fully blocked ready.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_BLOCK));
         stall_span = (stall_mode == STALL_BLOCK) ? $urandom_range(2, 12)
                                                  : $urandom_range(8, 64);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_ch.ready <= 1'b1;
         STALL_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ch.ready <= 1'b0;
      endcase
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   // Sends one scan tick; the sender works in bursts separated by gaps.
   task automatic send_tick(levels_type lv);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
      end
      req_ch.valid       <= 1'b1;
      req_ch.power_level <= lv.power_level;
      req_ch.set_level   <= lv.set_level;
      req_ch.down_level  <= lv.down_level;
      req_ch.up_level    <= lv.up_level;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
   endtask

   task automatic send_repeat(levels_type lv, int count);
      repeat (count) send_tick(lv);
   endtask

   // Stops sending and waits until every outstanding transaction has returned.
   // The first edge lets the checker record a transaction accepted just now.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_HOLD_TICKS:     cfg.hold_ticks     = value;
         REG_HOLD_CAP:       cfg.hold_cap       = value;
         REG_SET_PRESCALE:   cfg.set_prescale   = value[SubW-1:0];
         REG_SET_LONG_COUNT: cfg.set_long_count = value;
         REG_SET_SHORT_MIN:  cfg.set_short_min  = value;
         REG_SET_SHORT_MAX:  cfg.set_short_max  = value;
         REG_SET_CAP:        cfg.set_cap        = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_plain_limits(cnt_type ticks, cnt_type cap);
      wait_drained();
      write_reg(REG_HOLD_TICKS, ticks);
      write_reg(REG_HOLD_CAP, cap);
   endtask

   task automatic test_defaults();
      send_tick(make_levels(1, 1, 1, 1));
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   // Power hold masks the down counter on the tick it reports.
   task automatic test_priority_hold_release();
      write_plain_limits(16'd2, 16'd3);
      send_repeat(make_levels(1, 0, 1, 0), 4);
      send_tick(make_levels(0, 0, 0, 1));
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   task automatic test_set_short_long();
      wait_drained();
      write_reg(REG_SET_PRESCALE, 16'd0);
      write_reg(REG_SET_SHORT_MIN, 16'd0);
      write_reg(REG_SET_SHORT_MAX, 16'd3);
      write_reg(REG_SET_LONG_COUNT, 16'd2);
      write_reg(REG_SET_CAP, 16'd2);
      send_repeat(make_levels(0, 1, 0, 0), 3);
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   // A zero threshold never reports a hold but still gives a release.
   task automatic test_zero_threshold();
      write_plain_limits(16'd0, 16'd2);
      send_repeat(make_levels(0, 0, 0, 1), 3);
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   task automatic test_threshold_above_cap();
      write_plain_limits(16'd5, 16'd2);
      send_repeat(make_levels(1, 0, 0, 0), 3);
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   // The down button stays pressed across the write that lowers the cap.
   task automatic test_lowered_cap();
      write_plain_limits(16'd1, 16'd50);
      send_repeat(make_levels(0, 0, 1, 0), 3);
      wait_drained();
      write_reg(REG_HOLD_CAP, 16'd2);
      send_repeat(make_levels(0, 0, 1, 0), 2);
      send_tick(make_levels(0, 0, 0, 0));
   endtask

   task automatic test_register_extremes();
      wait_drained();
      for (int i = 0; i <= REG_SET_CAP; i++) write_reg(i[CsrIdxW-1:0], 16'hFFFF);
      send_tick(make_levels(1, 1, 1, 1));
      wait_drained();
      for (int i = 0; i <= REG_SET_CAP; i++) write_reg(i[CsrIdxW-1:0], 16'h0000);
      send_tick(make_levels(1, 1, 1, 1));
      send_tick(make_levels(0, 0, 0, 0));
      wait_drained();
      // Upper bits of the prescale write are dropped; the spare index is ignored.
      write_reg(REG_SET_PRESCALE, 16'hAB01);
      write_reg(UnusedRegIndex, 16'h5A5A);
      send_repeat(make_levels(0, 1, 0, 0), 2);
   endtask

   task automatic apply_random_settings();
      wait_drained();
      write_reg(REG_HOLD_TICKS, cnt_type'($urandom_range(0, 8)));
      write_reg(REG_HOLD_CAP,
                cnt_type'(($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(0, 14)));
      write_reg(REG_SET_PRESCALE, cnt_type'($urandom_range(0, 3)));
      write_reg(REG_SET_LONG_COUNT, cnt_type'($urandom_range(0, 10)));
      write_reg(REG_SET_SHORT_MIN, cnt_type'($urandom_range(0, 4)));
      write_reg(REG_SET_SHORT_MAX, cnt_type'($urandom_range(0, 12)));
      write_reg(REG_SET_CAP,
                cnt_type'(($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(0, 14)));
      if ($urandom_range(0, 3) == 0) write_reg(UnusedRegIndex, cnt_type'($urandom()));
   endtask

   // Each button alternates between presses of a length around its thresholds
   // and short releases; some ticks carry random levels instead.
   task automatic test_random_presses(int count);
      bit   btn_dn [4];
      int   btn_left [4];
      int   span;
      levels_type lv;
      for (int b = 0; b < 4; b++) begin
         btn_dn[b]   = 1'b0;
         btn_left[b] = $urandom_range(1, 4);
      end
      for (int n = 0; n < count; n++) begin
         for (int b = 0; b < 4; b++) begin
            btn_left[b]--;
            if (btn_left[b] <= 0) begin
               btn_dn[b] = !btn_dn[b];
               if (!btn_dn[b]) begin
                  btn_left[b] = $urandom_range(1, 3);
               end else begin
                  if (b == BTN_SET)
                     span = (int'(cfg.set_short_max) + 2) * (int'(cfg.set_prescale) + 1);
                  else
                     span = int'(cfg.hold_ticks) + 3;
                  if (span > 60) span = 60;
                  btn_left[b] = $urandom_range(1, span);
               end
            end
         end
         lv = make_levels(btn_dn[BTN_POWER], btn_dn[BTN_SET], btn_dn[BTN_DOWN], btn_dn[BTN_UP]);
         if ($urandom_range(0, 99) < NoisePercent)
            lv = levels_type'(4'($urandom_range(0, 15)));
         send_tick(lv);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.power_level <= 1'b1;
      req_ch.set_level   <= 1'b1;
      req_ch.down_level  <= 1'b1;
      req_ch.up_level    <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= REG_HOLD_TICKS;
      csr_wdata          <= '0;
      cfg = '{hold_ticks: RstHoldTicks, hold_cap: RstHoldCap,
              set_prescale: RstSetPrescale, set_long_count: RstSetLongCount,
              set_short_min: RstSetShortMin, set_short_max: RstSetShortMax,
              set_cap: RstSetCap};
      power_cnt   = '0;
      set_sub_cnt = '0;
      set_cnt     = '0;
      down_cnt    = '0;
      up_cnt      = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_priority_hold_release();
      test_set_short_long();
      test_zero_threshold();
      test_threshold_above_cap();
      test_lowered_cap();
      test_register_extremes();
      for (int p = 0; p < RandomPhases; p++) begin
         apply_random_settings();
         test_random_presses(PhaseTicks);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/fbpc_pkg.sv
rtl/fbpc_req_if.sv
rtl/fbpc_rsp_if.sv
rtl/fbpc_plain_btn.sv
rtl/fbpc_set_btn.sv
rtl/four_button_press_classifier.sv
bench/four_button_press_classifier_tb.sv
